/* src/lbd_pkg.sv */
// lbd_pkg: button codes, register indexes and fixed field widths
// for the resistor ladder button debouncer; no dependencies
`default_nettype none

package lbd_pkg;

  typedef enum logic [2:0] {
    BTN_NONE    = 3'd0,
    BTN_MAIN    = 3'd1,
    BTN_CANCEL  = 3'd2,
    BTN_RESUME  = 3'd3,
    BTN_SET     = 3'd4,
    BTN_UNKNOWN = 3'd5
  } button_t;

  typedef enum logic [2:0] {
    REG_MAIN_BAND       = 3'd0,
    REG_CANCEL_BAND     = 3'd1,
    REG_RESUME_BAND     = 3'd2,
    REG_SET_BAND        = 3'd3,
    REG_NEUTRAL_FLOOR   = 3'd4,
    REG_BAND_MARGIN     = 3'd5,
    REG_CONFIRM_TIME    = 3'd6,
    REG_LONG_PRESS_TIME = 3'd7
  } reg_index_t;

  localparam int BAND_W   = 24;
  localparam int LEVEL_W  = 12;
  localparam int CONF_W   = 16;
  localparam int TIME_W   = 32;
  localparam int CFG_W    = 32;
  localparam int OUT_BITS = 43;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [LEVEL_W-1:0] NEUTRAL_FLOOR_RST   = 12'd4095;
  localparam logic [CONF_W-1:0]  CONFIRM_TIME_RST    = 16'd50;
  localparam logic [TIME_W-1:0]  LONG_PRESS_TIME_RST = 32'd1000;

endpackage

`default_nettype wire

/* src/ladder_button_debouncer_core.sv */
// ladder_button_debouncer_core: classifies ladder samples into buttons,
// debounces with wrapping ms timestamps, tracks hold time and long press
// depends on lbd_pkg
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata: adc_sample, now_ms
//  m_axis    out  m_axis_tvalid/tready       tdata: confirmed, previous, candidate,
//                                                   just_changed, hold_ms, long press
//  cfg       in   cfg_valid/cfg_ready        cfg_index, cfg_data
//
// one word per cycle sustained while m_axis_tready is high; a word is held in the input register
// and its result is then loaded into the output register
// the debounce state updates in the same cycle as classification
// rst (synchronous) clears state, valid flags and loads register defaults
// while the output word waits on m_axis_tready the input register takes one
// more word, then s_axis_tready stays low until the output word is taken
// cfg_ready is always high
`default_nettype none

module ladder_button_debouncer_core #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [SAMPLE_BITS-1:0] adc_sample, [SAMPLE_BITS+31:SAMPLE_BITS] now_ms, rest zero
  input  wire logic [((SAMPLE_BITS+39)/8)*8-1:0] s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [2:0] confirmed_button, [5:3] previous_button, [8:6] candidate_button,
  // [9] just_changed, [41:10] hold_ms, [42] main_long_press, rest zero
  output logic [lbd_pkg::OUT_W-1:0]          m_axis_tdata,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [lbd_pkg::CFG_W-1:0]     cfg_data
);
  import lbd_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int EXW = (2 * SB > BAND_W) ? 2 * SB : BAND_W;
  localparam int CW  = ((SB > LEVEL_W) ? SB : LEVEL_W) + 1;

  // configuration
  logic [BAND_W-1:0]  main_band, cancel_band, resume_band, set_band;
  logic [LEVEL_W-1:0] neutral_floor, band_margin;
  logic [CONF_W-1:0]  confirm_time;
  logic [TIME_W-1:0]  long_press_time;

  // input register
  logic              in_valid;
  logic [SB-1:0]     in_sample;
  logic [TIME_W-1:0] in_now;

  // debounce state
  button_t           candidate_reg, confirmed_reg, previous_reg;
  logic [TIME_W-1:0] candidate_start, confirmed_start;
  logic              lockout_flag, long_latch;

  // output register
  logic              out_valid;
  button_t           out_confirmed, out_previous, out_candidate;
  logic              out_changed, out_long;
  logic [TIME_W-1:0] out_hold;

  logic advance;

  assign cfg_ready     = 1'b1;
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_band       <= '0;
      cancel_band     <= '0;
      resume_band     <= '0;
      set_band        <= '0;
      neutral_floor   <= NEUTRAL_FLOOR_RST;
      band_margin     <= '0;
      confirm_time    <= CONFIRM_TIME_RST;
      long_press_time <= LONG_PRESS_TIME_RST;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_MAIN_BAND:       main_band       <= cfg_data[BAND_W-1:0];
        REG_CANCEL_BAND:     cancel_band     <= cfg_data[BAND_W-1:0];
        REG_RESUME_BAND:     resume_band     <= cfg_data[BAND_W-1:0];
        REG_SET_BAND:        set_band        <= cfg_data[BAND_W-1:0];
        REG_NEUTRAL_FLOOR:   neutral_floor   <= cfg_data[LEVEL_W-1:0];
        REG_BAND_MARGIN:     band_margin     <= cfg_data[LEVEL_W-1:0];
        REG_CONFIRM_TIME:    confirm_time    <= cfg_data[CONF_W-1:0];
        REG_LONG_PRESS_TIME: long_press_time <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_sample <= s_axis_tdata[SB-1:0];
      in_now    <= s_axis_tdata[SB+TIME_W-1:SB];
    end
  end

  // band test with margin, done without wrap in CW bits
  function automatic logic band_hit(input logic [SB-1:0] s, input logic [BAND_W-1:0] band,
                                    input logic [LEVEL_W-1:0] m);
    logic [EXW-1:0] ext;
    logic [CW-1:0]  lo, hi, sv, mv;
    ext = EXW'(band);
    lo  = CW'(ext[SB-1:0]);
    hi  = CW'(ext[2*SB-1:SB]);
    sv  = CW'(s);
    mv  = CW'(m);
    return (sv + mv >= lo) && (sv <= hi + mv);
  endfunction

  logic [LEVEL_W-1:0] m_main, m_cancel, m_resume, m_set, m_none;
  button_t            raw;
  logic               cand_new, elapsed, confirm;
  logic [TIME_W-1:0]  hold_keep, held_time;

  button_t           candidate_next, confirmed_next, previous_next;
  logic [TIME_W-1:0] candidate_start_next, confirmed_start_next, hold_next;
  logic              lockout_next, long_latch_next, latch_clear, hold_long;

  always_comb begin
    m_main   = (confirmed_reg == BTN_MAIN)   ? band_margin : '0;
    m_cancel = (confirmed_reg == BTN_CANCEL) ? band_margin : '0;
    m_resume = (confirmed_reg == BTN_RESUME) ? band_margin : '0;
    m_set    = (confirmed_reg == BTN_SET)    ? band_margin : '0;
    m_none   = (confirmed_reg == BTN_NONE)   ? band_margin : '0;
    if (band_hit(in_sample, main_band, m_main)) begin
      raw = BTN_MAIN;
    end else if (band_hit(in_sample, cancel_band, m_cancel)) begin
      raw = BTN_CANCEL;
    end else if (band_hit(in_sample, resume_band, m_resume)) begin
      raw = BTN_RESUME;
    end else if (band_hit(in_sample, set_band, m_set)) begin
      raw = BTN_SET;
    end else if (CW'(in_sample) + CW'(m_none) >= CW'(neutral_floor)) begin
      raw = BTN_NONE;
    end else begin
      raw = BTN_UNKNOWN;
    end
  end

  always_comb begin
    cand_new             = (raw != candidate_reg);
    candidate_next       = raw;
    candidate_start_next = cand_new ? in_now : candidate_start;
    // a fresh candidate has held zero ms, so only a zero confirm time passes
    held_time = in_now - (candidate_start + TIME_W'(confirm_time));
    elapsed   = cand_new ? (confirm_time == '0) : !held_time[TIME_W-1];
    confirm   = elapsed && (raw != confirmed_reg) && !(lockout_flag && raw != BTN_NONE);

    confirmed_next       = confirm ? raw : confirmed_reg;
    previous_next        = confirm ? confirmed_reg : previous_reg;
    confirmed_start_next = confirm ? in_now : confirmed_start;
    lockout_next         = confirm ? (raw != BTN_NONE) : lockout_flag;
    latch_clear          = confirm && (raw != BTN_MAIN);

    hold_keep = in_now - confirmed_start;
    hold_next = confirm ? '0 : hold_keep;
    hold_long = confirm ? (long_press_time == '0) : (hold_keep >= long_press_time);
    long_latch_next = (long_latch && !latch_clear) ||
                      ((confirmed_next == BTN_MAIN) && hold_long);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      candidate_reg   <= BTN_NONE;
      candidate_start <= '0;
      confirmed_reg   <= BTN_NONE;
      previous_reg    <= BTN_NONE;
      confirmed_start <= '0;
      lockout_flag    <= 1'b0;
      long_latch      <= 1'b0;
    end else if (advance) begin
      candidate_reg   <= candidate_next;
      candidate_start <= candidate_start_next;
      confirmed_reg   <= confirmed_next;
      previous_reg    <= previous_next;
      confirmed_start <= confirmed_start_next;
      lockout_flag    <= lockout_next;
      long_latch      <= long_latch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_confirmed <= confirmed_next;
      out_previous  <= previous_next;
      out_candidate <= candidate_next;
      out_changed   <= confirm;
      out_hold      <= hold_next;
      out_long      <= (confirmed_next == BTN_MAIN) && long_latch_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_W'({out_long, out_hold, out_changed, out_candidate,
                                 out_previous, out_confirmed});

endmodule

`default_nettype wire
